// File: rtl/core/kst_pkg.sv
// Shared types, codes and default sizes for the keyed stock table.
package kst_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int KEY_BITS_DEF    = 20;
    localparam int QTY_BITS_DEF    = 16;

    localparam int OP_W            = 2;
    localparam int STATUS_W        = 3;
    localparam int ENTRY_INDEX_W   = 7;
    localparam int LEVEL_W         = 2;
    localparam int ENTRIES_USED_W  = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_MERGE  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_ACCUM    = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_DUP      = 3'd4,
        ST_FULL     = 3'd5,
        ST_BADKEY   = 3'd6,
        ST_BADTHR   = 3'd7
    } status_t;

    localparam logic [LEVEL_W-1:0] LVL_CRITICAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_LOW      = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_ADEQUATE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_SEARCH,
        S_RESOLVE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic pre;
        logic search;
        logic resolve;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pre_err;
        logic hit;
        logic miss;
    } sts_t;

endpackage

// File: rtl/core/kst_ctrl.sv
// Sequencer for the keyed stock table: accept, check, search, resolve, emit.
module kst_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          m_ready,
    output logic          m_valid,
    input  kst_pkg::sts_t sts,
    output kst_pkg::cmd_t cmd
);

    kst_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kst_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            kst_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = kst_pkg::S_PRE;
                end
            end
            kst_pkg::S_PRE: begin
                cmd.pre    = 1'b1;
                state_next = sts.pre_err ? kst_pkg::S_OUT : kst_pkg::S_SEARCH;
            end
            kst_pkg::S_SEARCH: begin
                cmd.search = 1'b1;
                if (sts.hit || sts.miss) begin
                    state_next = kst_pkg::S_RESOLVE;
                end
            end
            kst_pkg::S_RESOLVE: begin
                cmd.resolve = 1'b1;
                state_next  = kst_pkg::S_OUT;
            end
            kst_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = kst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = kst_pkg::S_IDLE;
            end
        endcase
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/kst_dp.sv
// Datapath: entry memory, linear search pipeline, op resolution, result register.
module kst_dp #(
    parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
    parameter int QTY_BITS    = kst_pkg::QTY_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kst_pkg::cmd_t                       cmd,
    output kst_pkg::sts_t                       sts,
    input  logic [kst_pkg::OP_W-1:0]            s_op,
    input  logic [KEY_BITS-1:0]                 s_key_id,
    input  logic [QTY_BITS-1:0]                 s_quantity,
    input  logic [QTY_BITS-1:0]                 s_threshold,
    input  logic                                s_keep_quantity,
    output logic [kst_pkg::STATUS_W-1:0]        m_status,
    output logic [kst_pkg::ENTRY_INDEX_W-1:0]   m_entry_index,
    output logic [QTY_BITS-1:0]                 m_quantity_now,
    output logic [QTY_BITS-1:0]                 m_threshold_now,
    output logic [kst_pkg::LEVEL_W-1:0]         m_stock_level,
    output logic                                m_saturated,
    output logic [kst_pkg::ENTRIES_USED_W-1:0]  m_entries_used
);

    localparam int IDX_BITS  = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int WORD_BITS = KEY_BITS + 2 * QTY_BITS;

    // entry word: {key, quantity, threshold}
    logic [WORD_BITS-1:0] mem [TABLE_DEPTH];

    kst_pkg::op_t          op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [QTY_BITS-1:0]   q_reg, t_reg;
    logic                  keep_reg;

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   ptr_reg, ptr_next;
    logic                  rvld_reg, rvld_next;
    logic [IDX_BITS-1:0]   ridx_reg;
    logic [WORD_BITS-1:0]  rdata_reg;

    logic                  found_reg;
    logic [IDX_BITS-1:0]   slot_reg;
    logic [QTY_BITS-1:0]   cur_q_reg, cur_t_reg;

    kst_pkg::status_t      res_status_reg, res_status_next;
    logic                  res_ok_reg, res_ok_next;
    logic [IDX_BITS-1:0]   res_slot_reg, res_slot_next;
    logic [QTY_BITS-1:0]   res_q_reg, res_q_next;
    logic [QTY_BITS-1:0]   res_t_reg, res_t_next;
    logic                  res_sat_reg, res_sat_next;

    logic                  full, key_zero, thr_zero;
    kst_pkg::status_t      pre_code;
    logic                  hit;
    logic [KEY_BITS-1:0]   rkey;
    logic [QTY_BITS:0]     sum;
    logic                  we;
    logic [IDX_BITS-1:0]   waddr;
    logic [WORD_BITS-1:0]  wdata;
    logic [kst_pkg::LEVEL_W-1:0] level;

    assign full     = (count_reg == CNT_BITS'(TABLE_DEPTH));
    assign key_zero = (key_reg == '0);
    assign thr_zero = (t_reg == '0);
    assign rkey     = rdata_reg[WORD_BITS-1 -: KEY_BITS];
    assign hit      = rvld_reg && (rkey == key_reg);

    // checks that need no search
    always_comb begin
        sts.pre_err = 1'b1;
        pre_code    = kst_pkg::ST_BADKEY;
        if (op_reg == kst_pkg::OP_INSERT && full) begin
            pre_code = kst_pkg::ST_FULL;
        end else if (key_zero) begin
            pre_code = kst_pkg::ST_BADKEY;
        end else if (op_reg == kst_pkg::OP_MERGE && thr_zero) begin
            pre_code = kst_pkg::ST_BADTHR;
        end else begin
            sts.pre_err = 1'b0;
        end
        sts.hit  = hit;
        sts.miss = !rvld_reg && (ptr_reg == count_reg);
    end

    // search pointer: one read issued per cycle, compared the cycle after
    always_comb begin
        ptr_next  = ptr_reg;
        rvld_next = 1'b0;
        if (cmd.pre) begin
            ptr_next = '0;
        end else if (cmd.search && !hit && (ptr_reg != count_reg)) begin
            ptr_next  = ptr_reg + CNT_BITS'(1);
            rvld_next = 1'b1;
        end
    end

    // op resolution after the search
    always_comb begin
        sum             = {1'b0, cur_q_reg} + {1'b0, q_reg};
        res_status_next = res_status_reg;
        res_ok_next     = res_ok_reg;
        res_slot_next   = res_slot_reg;
        res_q_next      = res_q_reg;
        res_t_next      = res_t_reg;
        res_sat_next    = 1'b0;
        count_next      = count_reg;
        we              = 1'b0;
        if (cmd.pre) begin
            res_status_next = pre_code;
            res_ok_next     = 1'b0;
        end else if (cmd.resolve) begin
            res_ok_next   = 1'b1;
            res_slot_next = slot_reg;
            res_q_next    = cur_q_reg;
            res_t_next    = cur_t_reg;
            case (op_reg)
                kst_pkg::OP_INSERT, kst_pkg::OP_MERGE: begin
                    if (found_reg && op_reg == kst_pkg::OP_INSERT) begin
                        res_status_next = kst_pkg::ST_DUP;
                        res_ok_next     = 1'b0;
                    end else if (found_reg) begin
                        res_status_next = kst_pkg::ST_ACCUM;
                        res_q_next      = sum[QTY_BITS] ? '1 : sum[QTY_BITS-1:0];
                        res_sat_next    = sum[QTY_BITS];
                        we              = 1'b1;
                    end else if (thr_zero) begin
                        res_status_next = kst_pkg::ST_BADTHR;
                        res_ok_next     = 1'b0;
                    end else if (full) begin
                        res_status_next = kst_pkg::ST_FULL;
                        res_ok_next     = 1'b0;
                    end else begin
                        res_status_next = kst_pkg::ST_INSERTED;
                        res_slot_next   = count_reg[IDX_BITS-1:0];
                        res_q_next      = q_reg;
                        res_t_next      = t_reg;
                        count_next      = count_reg + CNT_BITS'(1);
                        we              = 1'b1;
                    end
                end
                kst_pkg::OP_UPDATE, kst_pkg::OP_LOOKUP: begin
                    if (!found_reg) begin
                        res_status_next = kst_pkg::ST_NOTFOUND;
                        res_ok_next     = 1'b0;
                    end else begin
                        res_status_next = kst_pkg::ST_FOUND;
                        if (op_reg == kst_pkg::OP_UPDATE) begin
                            if (!keep_reg) res_q_next = q_reg;
                            if (!thr_zero) res_t_next = t_reg;
                            we = 1'b1;
                        end
                    end
                end
                default: begin
                    res_ok_next = 1'b0;
                end
            endcase
        end
        waddr = res_slot_next;
        wdata = {key_reg, res_q_next, res_t_next};
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rvld_reg  <= 1'b0;
            ptr_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            rvld_reg  <= rvld_next;
            ptr_reg   <= ptr_next;
            if (cmd.pre) begin
                found_reg <= 1'b0;
            end else if (cmd.search && hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    // memory: one registered read, one write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[ptr_reg[IDX_BITS-1:0]];
        ridx_reg  <= ptr_reg[IDX_BITS-1:0];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= kst_pkg::op_t'(s_op);
            key_reg  <= s_key_id;
            q_reg    <= s_quantity;
            t_reg    <= s_threshold;
            keep_reg <= s_keep_quantity;
        end
        if (cmd.search && hit) begin
            slot_reg  <= ridx_reg;
            cur_q_reg <= rdata_reg[2*QTY_BITS-1 -: QTY_BITS];
            cur_t_reg <= rdata_reg[QTY_BITS-1:0];
        end
        res_status_reg <= res_status_next;
        res_ok_reg     <= res_ok_next;
        res_slot_reg   <= res_slot_next;
        res_q_reg      <= res_q_next;
        res_t_reg      <= res_t_next;
        if (cmd.pre || cmd.resolve) begin
            res_sat_reg <= res_sat_next;
        end
    end

    always_comb begin
        if (res_q_reg <= (res_t_reg >> 1)) begin
            level = kst_pkg::LVL_CRITICAL;
        end else if (res_q_reg <= res_t_reg) begin
            level = kst_pkg::LVL_LOW;
        end else begin
            level = kst_pkg::LVL_ADEQUATE;
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status       <= res_status_reg;
            m_entries_used <= kst_pkg::ENTRIES_USED_W'(count_reg);
            if (res_ok_reg) begin
                m_entry_index   <= kst_pkg::ENTRY_INDEX_W'(res_slot_reg);
                m_quantity_now  <= res_q_reg;
                m_threshold_now <= res_t_reg;
                m_stock_level   <= level;
                m_saturated     <= res_sat_reg;
            end else begin
                m_entry_index   <= '0;
                m_quantity_now  <= '0;
                m_threshold_now <= '0;
                m_stock_level   <= '0;
                m_saturated     <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/keyed_stock_table.sv
// Top level of the keyed stock table: controller plus datapath.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one command word: op, key_id,
//   quantity, threshold, keep_quantity. Ops: insert, merge (accumulate or
//   insert), update, lookup. Result channel (m_valid/m_ready) returns exactly
//   one word per command: status, entry_index, quantity_now, threshold_now,
//   stock_level, saturated, entries_used.
// Timing:
//   One command at a time; keys are found by a linear scan, one memory read
//   per cycle. A hit ends the scan at its slot, a miss reads every filled
//   entry, and a reject before the scan (bad key, bad threshold on merge,
//   full on insert) skips it. s_ready is high again from the cycle m_valid
//   rises. While a result waits for m_ready the next command is accepted and
//   runs, holding in its final step until the waiting word is taken.
// Reset:
//   aresetn (synchronous, active low) empties the table by clearing the fill
//   count; memory is not cleared, entries past the count are never used.
module keyed_stock_table #(
    parameter int TABLE_DEPTH = kst_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
    parameter int QTY_BITS    = kst_pkg::QTY_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // command words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kst_pkg::OP_W-1:0]            s_op,
    input  logic [KEY_BITS-1:0]                 s_key_id,
    input  logic [QTY_BITS-1:0]                 s_quantity,
    input  logic [QTY_BITS-1:0]                 s_threshold,
    input  logic                                s_keep_quantity,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kst_pkg::STATUS_W-1:0]        m_status,
    output logic [kst_pkg::ENTRY_INDEX_W-1:0]   m_entry_index,
    output logic [QTY_BITS-1:0]                 m_quantity_now,
    output logic [QTY_BITS-1:0]                 m_threshold_now,
    output logic [kst_pkg::LEVEL_W-1:0]         m_stock_level,
    output logic                                m_saturated,
    output logic [kst_pkg::ENTRIES_USED_W-1:0]  m_entries_used
);

    kst_pkg::cmd_t cmd;   // sequencing strobes, one step per state
    kst_pkg::sts_t sts;   // early reject, key hit, scan exhausted

    kst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    kst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .QTY_BITS    (QTY_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_key_id        (s_key_id),
        .s_quantity      (s_quantity),
        .s_threshold     (s_threshold),
        .s_keep_quantity (s_keep_quantity),
        .m_status        (m_status),
        .m_entry_index   (m_entry_index),
        .m_quantity_now  (m_quantity_now),
        .m_threshold_now (m_threshold_now),
        .m_stock_level   (m_stock_level),
        .m_saturated     (m_saturated),
        .m_entries_used  (m_entries_used)
    );

endmodule

// File: sim/tb_keyed_stock_table.sv
// Self-checking testbench for keyed_stock_table: directed and random commands, scoreboard.
`timescale 1ns / 1ps

module tb_keyed_stock_table;

    localparam int DEPTH        = kst_pkg::TABLE_DEPTH_DEF;
    localparam int KW           = kst_pkg::KEY_BITS_DEF;
    localparam int QW           = kst_pkg::QTY_BITS_DEF;
    localparam int OW           = kst_pkg::OP_W;
    localparam int SW           = kst_pkg::STATUS_W;
    localparam int IW           = kst_pkg::ENTRY_INDEX_W;
    localparam int LW           = kst_pkg::LEVEL_W;
    localparam int UW           = kst_pkg::ENTRIES_USED_W;
    localparam int RANDOM_WORDS = 900;
    localparam int DRAIN_CYCLES = DEPTH + 40;   // a full-table scan plus margin
    localparam int REPORT_LIMIT = 10;

    // One result word as the block should present it.
    typedef struct {
        kst_pkg::status_t status;
        logic [IW-1:0]    index;
        logic [QW-1:0]    qty;
        logic [QW-1:0]    thr;
        logic [LW-1:0]    level;
        logic             sat;
        logic [UW-1:0]    used;
    } reply_t;

    // Shadow copy of the stock table; predicts the reply to every accepted
    // command word and checks the replies in order.
    class stock_ledger;
        logic [KW-1:0] keys [DEPTH];
        logic [QW-1:0] qtys [DEPTH];
        logic [QW-1:0] thrs [DEPTH];
        int            used;
        reply_t        owed_replies[$];
        int            mismatches;

        function new();
            used       = 0;
            mismatches = 0;
        endfunction

        // first match wins, only filled slots are searched
        function int slot_of(logic [KW-1:0] key);
            for (int i = 0; i < used; i++) begin
                if (keys[i] == key) return i;
            end
            return -1;
        endfunction

        function logic [LW-1:0] level_of(logic [QW-1:0] q, logic [QW-1:0] t);
            if (q <= (t >> 1)) return kst_pkg::LVL_CRITICAL;
            if (q <= t) return kst_pkg::LVL_LOW;
            return kst_pkg::LVL_ADEQUATE;
        endfunction

        // errors pass slot = -1: everything but status and count reads zero
        function void owe(kst_pkg::status_t st, int slot, logic sat);
            reply_t r;
            r.status = st;
            r.used   = UW'(used);
            if (slot >= 0) begin
                r.index = IW'(slot);
                r.qty   = qtys[slot];
                r.thr   = thrs[slot];
                r.level = level_of(qtys[slot], thrs[slot]);
                r.sat   = sat;
            end else begin
                r.index = '0;
                r.qty   = '0;
                r.thr   = '0;
                r.level = '0;
                r.sat   = 1'b0;
            end
            owed_replies.push_back(r);
        endfunction

        function int append(logic [KW-1:0] key, logic [QW-1:0] q, logic [QW-1:0] t);
            keys[used] = key;
            qtys[used] = q;
            thrs[used] = t;
            used++;
            return used - 1;
        endfunction

        function void note_command(kst_pkg::op_t op, logic [KW-1:0] key, logic [QW-1:0] q,
                                   logic [QW-1:0] t, logic keep);
            int         slot;
            logic       full;
            logic [QW:0] sum;
            full = (used >= DEPTH);
            if (op == kst_pkg::OP_INSERT) begin
                // full outranks every other insert error
                if (full) owe(kst_pkg::ST_FULL, -1, 1'b0);
                else if (key == '0) owe(kst_pkg::ST_BADKEY, -1, 1'b0);
                else if (slot_of(key) >= 0) owe(kst_pkg::ST_DUP, -1, 1'b0);
                else if (t == '0) owe(kst_pkg::ST_BADTHR, -1, 1'b0);
                else owe(kst_pkg::ST_INSERTED, append(key, q, t), 1'b0);
                return;
            end
            if (key == '0) begin
                owe(kst_pkg::ST_BADKEY, -1, 1'b0);
                return;
            end
            if (op == kst_pkg::OP_MERGE) begin
                if (t == '0) begin
                    owe(kst_pkg::ST_BADTHR, -1, 1'b0);
                    return;
                end
                slot = slot_of(key);
                if (slot >= 0) begin
                    // hit: add with clipping, threshold untouched
                    sum = {1'b0, qtys[slot]} + {1'b0, q};
                    qtys[slot] = sum[QW] ? {QW{1'b1}} : sum[QW-1:0];
                    owe(kst_pkg::ST_ACCUM, slot, sum[QW]);
                end else if (full) begin
                    owe(kst_pkg::ST_FULL, -1, 1'b0);
                end else begin
                    owe(kst_pkg::ST_INSERTED, append(key, q, t), 1'b0);
                end
                return;
            end
            slot = slot_of(key);
            if (slot < 0) begin
                owe(kst_pkg::ST_NOTFOUND, -1, 1'b0);
                return;
            end
            if (op == kst_pkg::OP_UPDATE) begin
                if (!keep) qtys[slot] = q;
                if (t != '0) thrs[slot] = t;
            end
            owe(kst_pkg::ST_FOUND, slot, 1'b0);
        endfunction

        function void check_word(reply_t got);
            reply_t want;
            if (owed_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result word with none outstanding: st=%0d idx=%0d",
                             $realtime, got.status, got.index);
                return;
            end
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.qty !== want.qty || got.thr !== want.thr ||
                got.level !== want.level || got.sat !== want.sat ||
                got.used !== want.used) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display({"%0t: mismatch exp st=%0d idx=%0d qty=%0d thr=%0d",
                              " lvl=%0d sat=%0d used=%0d"},
                             $realtime, want.status, want.index, want.qty, want.thr,
                             want.level, want.sat, want.used);
                    $display({"%0t:          got st=%0d idx=%0d qty=%0d thr=%0d",
                              " lvl=%0d sat=%0d used=%0d"},
                             $realtime, got.status, got.index, got.qty, got.thr,
                             got.level, got.sat, got.used);
                end
            end
        endfunction
    endclass

    logic                aclk            = 1'b0;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OW-1:0]       s_op            = '0;
    logic [KW-1:0]       s_key_id        = '0;
    logic [QW-1:0]       s_quantity      = '0;
    logic [QW-1:0]       s_threshold     = '0;
    logic                s_keep_quantity = 1'b0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [SW-1:0]       m_status;
    logic [IW-1:0]       m_entry_index;
    logic [QW-1:0]       m_quantity_now;
    logic [QW-1:0]       m_threshold_now;
    logic [LW-1:0]       m_stock_level;
    logic                m_saturated;
    logic [UW-1:0]       m_entries_used;

    // calm = no idling on either side
    logic                calm            = 1'b0;
    stock_ledger         ledger;

    keyed_stock_table u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_key_id        (s_key_id),
        .s_quantity      (s_quantity),
        .s_threshold     (s_threshold),
        .s_keep_quantity (s_keep_quantity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_index   (m_entry_index),
        .m_quantity_now  (m_quantity_now),
        .m_threshold_now (m_threshold_now),
        .m_stock_level   (m_stock_level),
        .m_saturated     (m_saturated),
        .m_entries_used  (m_entries_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: sample the handshake as it stood at the edge, then pick
    // next cycle's ready. Single NBA to m_ready per edge.
    always @(posedge aclk) begin : take_replies
        reply_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status = kst_pkg::status_t'(m_status);
            got.index  = m_entry_index;
            got.qty    = m_quantity_now;
            got.thr    = m_threshold_now;
            got.level  = m_stock_level;
            got.sat    = m_saturated;
            got.used   = m_entries_used;
            ledger.check_word(got);
        end
        m_ready <= calm || ($urandom_range(0, 99) >= 13);
    end

    // Command side. Valid is only dropped inside an idle gap, so back-to-back
    // words never see a low and a high NBA in the same step.
    task automatic send_command(kst_pkg::op_t op, logic [KW-1:0] key, logic [QW-1:0] qty,
                                logic [QW-1:0] thr, logic keep);
        while (!calm && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_key_id        <= key;
        s_quantity      <= qty;
        s_threshold     <= thr;
        s_keep_quantity <= keep;
        do @(posedge aclk); while (!s_ready);
        ledger.note_command(op, key, qty, thr, keep);
    endtask

    // key not yet in the table, never zero
    function automatic logic [KW-1:0] fresh_key();
        logic [KW-1:0] k;
        do k = KW'($urandom()); while (k == '0 || ledger.slot_of(k) >= 0);
        return k;
    endfunction

    // mostly live keys so searches hit at every depth; some zero and edge keys
    function automatic logic [KW-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6) return '0;
        if (roll == 6) return KW'(1);
        if (roll < 9) return {KW{1'b1}};
        if (ledger.used > 0 && roll < (ledger.used < DEPTH ? 62 : 90))
            return ledger.keys[$urandom_range(0, ledger.used - 1)];
        return fresh_key();
    endfunction

    // bias toward both ends so clipping and level boundaries get hit
    function automatic logic [QW-1:0] pick_amount();
        case ($urandom_range(0, 4))
            0:       return QW'($urandom_range(0, 40));
            1:       return {QW{1'b1}} - QW'($urandom_range(0, 40));
            2:       return QW'($urandom_range(0, 1000));
            default: return QW'($urandom());
        endcase
    endfunction

    function automatic logic [QW-1:0] pick_threshold();
        if ($urandom_range(0, 99) < 10) return '0;
        return pick_amount();
    endfunction

    initial begin : stimulus
        logic [KW-1:0] far_key;
        ledger = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed: empty table, key and threshold errors
        send_command(kst_pkg::OP_LOOKUP, KW'(1), '0, '0, 1'b0);          // not found, empty
        send_command(kst_pkg::OP_UPDATE, {KW{1'b1}}, '1, '1, 1'b1);      // not found
        send_command(kst_pkg::OP_INSERT, '0, QW'(3), QW'(5), 1'b0);      // bad key
        send_command(kst_pkg::OP_MERGE, '0, '0, '0, 1'b0);               // bad key beats thr
        send_command(kst_pkg::OP_UPDATE, '0, QW'(1), QW'(1), 1'b0);      // bad key
        send_command(kst_pkg::OP_INSERT, KW'(1), '0, '0, 1'b0);          // bad threshold
        send_command(kst_pkg::OP_MERGE, KW'(5), QW'(9), '0, 1'b0);       // bad threshold
        // --- inserts at field extremes
        send_command(kst_pkg::OP_INSERT, KW'(1), '0, '1, 1'b0);          // slot 0, critical
        send_command(kst_pkg::OP_INSERT, KW'(1), '0, '0, 1'b0);          // dup beats thr
        send_command(kst_pkg::OP_INSERT, {KW{1'b1}}, '1, QW'(1), 1'b0);  // slot 1, adequate
        // --- merge: clipping, exact max, level boundaries, threshold kept
        // clipped, thr stays 1
        send_command(kst_pkg::OP_MERGE, {KW{1'b1}}, QW'(1), QW'(7), 1'b0);
        // q == t/2: critical
        send_command(kst_pkg::OP_MERGE, KW'(1), QW'(16'h7FFF), QW'(9), 1'b0);
        // just above: low
        send_command(kst_pkg::OP_MERGE, KW'(1), QW'(1), QW'(9), 1'b0);
        // sum hits max, no clip
        send_command(kst_pkg::OP_MERGE, KW'(1), QW'(16'h7FFF), QW'(2), 1'b0);
        // clipped again
        send_command(kst_pkg::OP_MERGE, KW'(1), '1, QW'(2), 1'b0);
        // absent: inserted
        send_command(kst_pkg::OP_MERGE, KW'(20'h12345), QW'(10), QW'(20), 1'b0);
        // --- update: keep flag and zero threshold both mean leave alone
        // qty 99, thr 20
        send_command(kst_pkg::OP_UPDATE, KW'(20'h12345), QW'(99), '0, 1'b0);
        // qty kept
        send_command(kst_pkg::OP_UPDATE, KW'(20'h12345), QW'(7), QW'(21), 1'b1);
        // q == t/2
        send_command(kst_pkg::OP_UPDATE, KW'(20'h12345), QW'(10), QW'(20), 1'b0);
        // q == t: low
        send_command(kst_pkg::OP_UPDATE, KW'(20'h12345), QW'(20), '0, 1'b0);
        send_command(kst_pkg::OP_LOOKUP, {KW{1'b1}}, '1, '1, 1'b1);      // found, slot 1
        send_command(kst_pkg::OP_LOOKUP, '0, '0, '0, 1'b0);              // bad key

        // --- random part; a stretch in the middle runs with no idling at all
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            calm <= (n >= 250 && n < 400);
            if (n == 600) begin
                // make sure the table is full for the last third
                while (ledger.used < DEPTH)
                    send_command(kst_pkg::OP_INSERT, fresh_key(), pick_amount(),
                                 QW'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
                far_key = fresh_key();
                // full beats bad key, then full beats dup
                send_command(kst_pkg::OP_INSERT, '0, '0, '0, 1'b0);
                send_command(kst_pkg::OP_INSERT, ledger.keys[0], QW'(1), QW'(1), 1'b0);
                // absent on full, then the deepest slot
                send_command(kst_pkg::OP_MERGE, far_key, QW'(5), QW'(5), 1'b0);
                send_command(kst_pkg::OP_LOOKUP, ledger.keys[DEPTH-1], '0, '0, 1'b0);
            end
            send_command(kst_pkg::op_t'($urandom_range(0, 3)), pick_key(), pick_amount(),
                         pick_threshold(), 1'($urandom_range(0, 1)));
        end
        s_valid <= 1'b0;

        // drain, then give a late stray word a chance to show up
        while (ledger.owed_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ~1000 words, each a scan at worst over the full table, plus idling is ~2 ms
    initial begin : watchdog
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/kst_pkg.sv
rtl/core/kst_ctrl.sv
rtl/core/kst_dp.sv
rtl/core/keyed_stock_table.sv
sim/tb_keyed_stock_table.sv
